>>> rtl/core/cbms_pkg.sv
// ----------------------------------------------------------------------------
// cbms_pkg
// Shared types and constants of the cosine best-match search block.
// ----------------------------------------------------------------------------
package cbms_pkg;

  localparam int unsigned FeatW = 16;
  localparam int unsigned SimW  = 16;

  // Table geometry. The request fields are sized for exactly these values.
  localparam int unsigned DB_ENTRIES = 64;
  localparam int unsigned VEC_DIM    = 128;

  // Command codes of an input request.
  localparam logic CMD_DB_WRITE = 1'b0;
  localparam logic CMD_QUERY    = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ENTRY_COUNT = 1'b0;
  localparam logic CFG_THRESHOLD   = 1'b1;

  // A real-valued denominator below 1e-8 in the fixed-point scale.
  localparam logic [63:0] DENOM_MIN = 64'd175922;

  localparam logic signed [SimW-1:0] SIM_MIN = 16'sh8000;
  localparam logic signed [SimW-1:0] SIM_MAX = 16'sh7fff;

  typedef struct packed {
    logic              cmd;
    logic [5:0]        entry_index;
    logic [6:0]        element_index;
    logic signed [15:0] feature_value;
    logic              last;
  } cbms_in_t;

  typedef struct packed {
    logic [5:0]         best_entry;
    logic signed [15:0] similarity;
    logic               known;
  } cbms_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QNORM,
    ST_QROOT,
    ST_ENTRY,
    ST_EROOT,
    ST_DENOM,
    ST_DIV,
    ST_CMP,
    ST_OUT
  } cbms_state_t;

endpackage

>>> rtl/core/cbms_sqrt.sv
// ----------------------------------------------------------------------------
// cbms_sqrt
// Iterative 64-bit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cbms_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] x_r, x_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] one_r, one_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    x_nxt    = x_r;
    res_nxt  = res_r;
    one_nxt  = one_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = radicand;
      res_nxt  = '0;
      one_nxt  = 64'h4000_0000_0000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= res_r + one_r) begin
        x_nxt   = x_r - (res_r + one_r);
        res_nxt = (res_r >> 1) + one_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      one_nxt = one_r >> 2;
      if (one_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    res_r <= res_nxt;
    one_r <= one_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];
endmodule

>>> rtl/core/cosine_best_match_search.sv
// ----------------------------------------------------------------------------
// cosine_best_match_search
// Cosine nearest-neighbor search over a stored table of feature vectors.
// ----------------------------------------------------------------------------
// Database elements (cmd 0) and query elements (cmd 1) are written to their
// memories and produce no result. A query request with last set starts a
// search that holds the input stalled until the result is delivered. The
// search streams the query once to form its norm and takes its square root.
// Then, per entry, it streams that entry through a dot-product and a norm
// multiply-accumulate, takes that norm's square root, forms the denominator,
// runs a restoring division (skipped when the denominator is too small) and
// compares the result with the best so far. The database memory is read one
// element at a time and the divider is serial. One result is produced per
// search; entry_count 0 gives similarity 0.
module cosine_best_match_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbms_pkg::cbms_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cbms_pkg::cbms_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import cbms_pkg::*;

  localparam int unsigned EW = (DB_ENTRIES > 1) ? $clog2(DB_ENTRIES) : 1;
  localparam int unsigned FW = (VEC_DIM > 1) ? $clog2(VEC_DIM) : 1;
  localparam int unsigned AW = EW + FW;
  // The dividend is |dot| * 2^31; |dot| needs up to 38 bits.
  localparam int unsigned DivW = 69;

  // Feature storage; contents are undefined until written.
  logic [FeatW-1:0] db_mem [DB_ENTRIES*VEC_DIM];
  logic [FeatW-1:0] q_mem  [VEC_DIM];
  logic signed [FeatW-1:0] db_rd_r, q_rd_r;

  cbms_state_t state_r, state_nxt;
  logic [6:0]          entry_count_r;
  logic signed [15:0]  threshold_r;
  logic [FW:0]         elem_r, elem_nxt;      // stream counter
  logic [EW:0]         ent_r, ent_nxt;        // current entry
  logic [EW:0]         count_r;               // entries to search
  logic                rd_vld_r, rd_vld_nxt;  // memory data valid this cycle
  logic signed [63:0]  dot_r;
  logic [63:0]         norm_r;
  logic [31:0]         qroot_r, eroot_r;
  logic [63:0]         denom_r;
  logic [63:0]         rem_r;
  logic [DivW-1:0]     quo_r;
  logic [6:0]          div_cnt_r;
  logic                neg_r;
  logic signed [15:0]  sim_r, best_sim_r;
  logic [EW-1:0]       best_r;
  logic                chosen_r;
  logic                out_valid_r;
  cbms_out_t           out_data_r;

  logic        in_acc;
  logic        sq_start, sq_done;
  logic [63:0] sq_in;
  logic [31:0] sq_root;
  logic [EW:0] count_clip;

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign count_clip = (entry_count_r > 7'(DB_ENTRIES)) ? (EW+1)'(DB_ENTRIES)
                                                        : (EW+1)'(entry_count_r);

  // Memory writes and registered reads.
  logic [AW-1:0] rd_addr;
  assign rd_addr = {ent_r[EW-1:0], elem_r[FW-1:0]};

  always_ff @(posedge clk) begin
    if (in_acc && in_data.cmd == CMD_DB_WRITE &&
        32'(in_data.entry_index) < DB_ENTRIES &&
        32'(in_data.element_index) < VEC_DIM) begin
      db_mem[{in_data.entry_index[EW-1:0], in_data.element_index[FW-1:0]}]
        <= in_data.feature_value;
    end
    if (in_acc && in_data.cmd == CMD_QUERY &&
        32'(in_data.element_index) < VEC_DIM) begin
      q_mem[in_data.element_index[FW-1:0]] <= in_data.feature_value;
    end
    db_rd_r <= db_mem[rd_addr];
    q_rd_r  <= q_mem[elem_r[FW-1:0]];
  end

  cbms_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .radicand(sq_in),
    .done    (sq_done),
    .root    (sq_root)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_data.cmd == CMD_QUERY && in_data.last) begin
                  state_nxt = (count_clip == '0) ? ST_OUT : ST_QNORM;
                end
      ST_QNORM: if (rd_vld_r && !rd_vld_nxt) state_nxt = ST_QROOT;
      ST_QROOT: if (sq_done) state_nxt = ST_ENTRY;
      ST_ENTRY: if (rd_vld_r && !rd_vld_nxt) state_nxt = ST_EROOT;
      ST_EROOT: if (sq_done) state_nxt = ST_DENOM;
      ST_DENOM: state_nxt = ST_DIV;
      ST_DIV:   if (denom_r < DENOM_MIN || div_cnt_r == 7'(DivW)) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = (ent_r + 1'b1 == count_r) ? ST_OUT : ST_ENTRY;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Stream counter control.
  always_comb begin
    elem_nxt   = elem_r;
    rd_vld_nxt = 1'b0;
    ent_nxt    = ent_r;
    sq_start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        elem_nxt = '0;
        ent_nxt  = '0;
      end
      ST_QNORM, ST_ENTRY: begin
        if (elem_r < (FW+1)'(VEC_DIM)) begin
          elem_nxt   = elem_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && elem_r == (FW+1)'(VEC_DIM)) begin
          sq_start = 1'b1;
        end
      end
      ST_QROOT: begin
        // The first entry streams from element 0.
        elem_nxt = '0;
      end
      ST_CMP: begin
        ent_nxt  = ent_r + 1'b1;
        elem_nxt = '0;
      end
      default: ;
    endcase
  end

  // Datapath.
  logic signed [31:0] prod_q, prod_e;
  logic [64:0]        rem_sh;
  logic [63:0]        dot_mag;
  logic signed [15:0] sim_calc;
  always_comb begin
    prod_q  = q_rd_r * db_rd_r;
    prod_e  = (state_r == ST_QNORM) ? q_rd_r * q_rd_r : db_rd_r * db_rd_r;
    rem_sh  = {rem_r, quo_r[DivW-1]};
    dot_mag = dot_r[63] ? 64'(-dot_r) : 64'(dot_r);
  end

  // The root starts in the cycle that adds the last square, so that square
  // is folded into the radicand here.
  assign sq_in = (norm_r + 64'(unsigned'(prod_e))) << 16;

  always_comb begin
    if (neg_r) sim_calc = (quo_r >= 64'd32768) ? SIM_MIN : -16'(quo_r[15:0]);
    else       sim_calc = (quo_r >= 64'd32767) ? SIM_MAX : 16'(quo_r[15:0]);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        norm_r     <= '0;
        dot_r      <= '0;
        count_r    <= count_clip;
        best_sim_r <= SIM_MIN;
        best_r     <= '0;
        chosen_r   <= 1'b0;
      end
      ST_QNORM: if (rd_vld_r) norm_r <= norm_r + 64'(unsigned'(prod_e));
      ST_QROOT: if (sq_done) begin
        qroot_r <= sq_root;
        norm_r  <= '0;
        dot_r   <= '0;
      end
      ST_ENTRY: if (rd_vld_r) begin
        norm_r <= norm_r + 64'(unsigned'(prod_e));
        dot_r  <= dot_r + 64'(prod_q);
      end
      ST_EROOT: if (sq_done) eroot_r <= sq_root;
      ST_DENOM: begin
        denom_r   <= qroot_r * eroot_r;
        neg_r     <= dot_r[63];
        // Dividend is |dot| * 2^31; shifted in one bit a cycle from quo_r.
        quo_r     <= {dot_mag[DivW-32:0], 31'b0};
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV: if (denom_r >= DENOM_MIN && div_cnt_r != 7'(DivW)) begin
        if (rem_sh >= {1'b0, denom_r}) begin
          rem_r <= 64'(rem_sh - {1'b0, denom_r});
          quo_r <= {quo_r[DivW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[63:0];
          quo_r <= {quo_r[DivW-2:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r + 1'b1;
      end else begin
        sim_r <= (denom_r < DENOM_MIN) ? '0 : sim_calc;
      end
      ST_CMP: begin
        if (sim_r > best_sim_r) begin
          best_sim_r <= sim_r;
          best_r     <= ent_r[EW-1:0];
          chosen_r   <= 1'b1;
        end
        norm_r <= '0;
        dot_r  <= '0;
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      out_data_r.best_entry <= 6'(best_r);
      out_data_r.similarity <= (count_r == '0) ? '0 : best_sim_r;
      out_data_r.known      <= (count_r != '0) && chosen_r && (best_sim_r > threshold_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      elem_r        <= '0;
      ent_r         <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
      threshold_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      elem_r   <= elem_nxt;
      ent_r    <= ent_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (state_r == ST_OUT) out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: entry_count_r <= cfg_data[6:0];
          CFG_THRESHOLD:   threshold_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input is stalled whenever a search is running.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken during search");
  // Every result comes from the result state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_OUT) else $error("stray result");
  // Known is only reported with a similarity above the threshold.
  a_known_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.known) |-> out_data.similarity > threshold_r)
    else $error("known below threshold");
endmodule
